@@ src/sfa_pkg.sv @@
// Shared types, codes and constants of the source failover arbiter.
// No dependencies; every other file but sfa_if.sv imports this package.
package sfa_pkg;

  localparam int NUM_SOURCES = 8;
  localparam int SRC_W       = 3;
  localparam int TMO_NS_W    = 52;
  localparam int LEASE_NS_W  = 36;

  localparam logic [19:0] NS_PER_MS = 20'd1000000;

  localparam logic [TMO_NS_W-1:0] TMO_RST_NS  = 52'd100000000;
  localparam logic [TMO_NS_W-1:0] HOLD_RST_NS = 52'd200000000;

  localparam logic [2:0] CFG_CMD_TIMEOUT = 3'd0;
  localparam logic [2:0] CFG_SWITCH_HOLD = 3'd1;
  localparam logic [2:0] CFG_PRIORITIES  = 3'd2;
  localparam logic [2:0] CFG_LEASE_LOW   = 3'd3;
  localparam logic [2:0] CFG_LEASE_HIGH  = 3'd4;

  typedef enum logic [1:0] {
    OP_EVAL   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_LOST     = 3'd1,
    EV_FIRST    = 3'd2,
    EV_FALLBACK = 3'd3,
    EV_SWITCH   = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_PRIO       = 2'd1,
    ERR_STEADY     = 2'd2,
    ERR_CHALLENGER = 2'd3
  } err_t;

  // Running result of a scan, handed from one slot cell to the next.
  typedef struct packed {
    err_t             err;
    logic             any;
    logic [SRC_W-1:0] best_idx;
    logic [7:0]       best_prio;
    logic [63:0]      best_stamp;
    logic             act_qual;
    logic [63:0]      act_stamp;
  } scan_t;

  // Slot update command from the controller to one cell.
  typedef struct packed {
    logic        load;
    logic        remove;
    logic [7:0]  prio;
    logic [63:0] stamp;
    logic [62:0] recv;
  } slot_wr_t;

endpackage

@@ src/sfa_if.sv @@
// Handshake channels of the source failover arbiter: command, result, config.
// Depends on nothing; field widths follow the block's item formats.
interface sfa_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  source_index;
  logic [7:0]  snapshot_priority;
  logic [63:0] source_stamp;
  logic [62:0] received_time;
  logic [63:0] now_ros_time;
  logic [62:0] now_steady_time;
  modport source(output valid, opcode, source_index, snapshot_priority, source_stamp,
                 received_time, now_ros_time, now_steady_time, input ready);
  modport sink(input valid, opcode, source_index, snapshot_priority, source_stamp,
               received_time, now_ros_time, now_steady_time, output ready);
endinterface

interface sfa_res_if;
  logic        valid;
  logic        ready;
  logic        has_selection;
  logic [2:0]  selected_source;
  logic [63:0] selected_stamp;
  logic [2:0]  decision_event;
  logic [1:0]  error_code;
  modport source(output valid, has_selection, selected_source, selected_stamp,
                 decision_event, error_code, input ready);
  modport sink(input valid, has_selection, selected_source, selected_stamp,
               decision_event, error_code, output ready);
endinterface

interface sfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ src/sfa_cell.sv @@
// One source slot: holds the snapshot and folds its verdict into the scan beat.
// Depends on sfa_pkg.
module sfa_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sfa_pkg::SRC_W-1:0]     idx,
  input  sfa_pkg::slot_wr_t             wr,
  input  logic [7:0]                    policy_prio,
  input  logic [sfa_pkg::LEASE_NS_W-1:0] lease_ns,
  input  logic [sfa_pkg::TMO_NS_W-1:0]  tmo_ns,
  input  logic [63:0]                   now_ros,
  input  logic [62:0]                   eval_steady,
  input  logic [sfa_pkg::SRC_W-1:0]     active_index,
  input  sfa_pkg::scan_t                carry_in,
  input  logic                          valid_in,
  output sfa_pkg::scan_t                carry_out,
  output logic                          valid_out
);
  import sfa_pkg::*;

  logic        present;
  logic [7:0]  slot_prio;
  logic [63:0] slot_stamp;
  logic [62:0] slot_recv;

  logic        prio_ok, recv_ok, lease_ok, fresh, qual, better;
  logic [62:0] lease_age;
  logic [63:0] cmd_age;
  scan_t       scan_next;

  always_comb begin
    prio_ok   = (slot_prio == policy_prio);
    recv_ok   = (eval_steady >= slot_recv);
    lease_age = eval_steady - slot_recv;
    lease_ok  = (lease_age <= {{(63-LEASE_NS_W){1'b0}}, lease_ns});
    cmd_age   = now_ros - slot_stamp;
    fresh     = !now_ros[63] && !slot_stamp[63] &&
                (($signed(slot_stamp) > $signed(now_ros)) ||
                 (cmd_age <= {{(64-TMO_NS_W){1'b0}}, tmo_ns}));
    qual      = present && prio_ok && recv_ok && fresh && lease_ok;
    // A younger command means a later stamp, since now is shared by all slots.
    better    = !carry_in.any || (slot_prio > carry_in.best_prio) ||
                ((slot_prio == carry_in.best_prio) &&
                 ($signed(slot_stamp) > $signed(carry_in.best_stamp)));
    scan_next = carry_in;
    if (carry_in.err == ERR_NONE && present) begin
      if (!prio_ok) begin
        scan_next.err = ERR_PRIO;
      end else if (!recv_ok) begin
        scan_next.err = ERR_STEADY;
      end else if (qual) begin
        if (better) begin
          scan_next.any        = 1'b1;
          scan_next.best_idx   = idx;
          scan_next.best_prio  = slot_prio;
          scan_next.best_stamp = slot_stamp;
        end
        if (active_index == idx) begin
          scan_next.act_qual  = 1'b1;
          scan_next.act_stamp = slot_stamp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
      if (wr.load) begin
        present <= 1'b1;
      end else if (wr.remove) begin
        present <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.load) begin
      slot_prio  <= wr.prio;
      slot_stamp <= wr.stamp;
      slot_recv  <= wr.recv;
    end
    if (valid_in) begin
      carry_out <= scan_next;
    end
  end

endmodule

@@ src/source_failover_arbiter.sv @@
// Source failover arbiter: a row of slot cells walked by one scan beat at a time.
// Load and remove take effect in the accept cycle; the block is ready again next cycle.
// Evaluate: the scan beat walks the cell chain, registered in each cell in turn, and the
// result is written from S_FINISH once the result register is free; one evaluate is in
// flight at a time, so the next one is accepted only after the last one's result is written.
// Reset (rst, synchronous) empties every slot, clears arbitration state and restores defaults.
module source_failover_arbiter (
  input logic     clk,
  input logic     rst,
  sfa_cmd_if.sink cmd,
  sfa_res_if.source res,
  sfa_cfg_if.sink cfg
);
  import sfa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t state;

  // Configuration, kept in nanoseconds so the cells compare directly.
  logic [TMO_NS_W-1:0]   tmo_ns;
  logic [TMO_NS_W-1:0]   hold_ns;
  logic [63:0]           src_prio;
  logic [LEASE_NS_W-1:0] lease_ns [NUM_SOURCES];
  logic [TMO_NS_W-1:0]   cfg_ms_prod;
  logic [LEASE_NS_W-1:0] lease_prod [4];

  // Arbitration state.
  logic             act_v, ch_v;
  logic [SRC_W-1:0] act_i, ch_i;
  logic [62:0]      since;

  // Evaluate operands held for the whole scan.
  logic [63:0] now_ros;
  logic [62:0] eval_steady;
  logic        start;

  scan_t    chain   [NUM_SOURCES+1];
  logic     chain_v [NUM_SOURCES+1];
  slot_wr_t wr      [NUM_SOURCES];

  // Result register.
  logic             res_valid, out_has;
  logic [SRC_W-1:0] out_src;
  logic [63:0]      out_stamp;
  ev_t              out_ev;
  err_t             out_err;

  logic cmd_take, finish;

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign cmd_take  = cmd.valid && cmd.ready;
  assign finish    = (state == S_FINISH) && (!res_valid || res.ready);

  assign res.valid           = res_valid;
  assign res.has_selection   = out_has;
  assign res.selected_source = out_src;
  assign res.selected_stamp  = out_stamp;
  assign res.decision_event  = out_ev;
  assign res.error_code      = out_err;

  // The multiplications by one million happen as the register is written.
  always_comb begin
    cfg_ms_prod = cfg.data[31:0] * NS_PER_MS;
    for (int k = 0; k < 4; k++) begin
      lease_prod[k] = cfg.data[16*k +: 16] * NS_PER_MS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tmo_ns   <= TMO_RST_NS;
      hold_ns  <= HOLD_RST_NS;
      src_prio <= '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        lease_ns[i] <= '0;
      end
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_CMD_TIMEOUT: tmo_ns   <= cfg_ms_prod;
        CFG_SWITCH_HOLD: hold_ns  <= cfg_ms_prod;
        CFG_PRIORITIES:  src_prio <= cfg.data;
        CFG_LEASE_LOW: begin
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (i < 4) lease_ns[i] <= lease_prod[i[1:0]];
          end
        end
        CFG_LEASE_HIGH: begin
          for (int i = 0; i < NUM_SOURCES; i++) begin
            if (i >= 4) lease_ns[i] <= lease_prod[i[1:0]];
          end
        end
        default: ;
      endcase
    end
  end

  // The scan enters the chain with an empty verdict.
  assign chain[0]   = '0;
  assign chain_v[0] = start;

  for (genvar g = 0; g < NUM_SOURCES; g++) begin : g_cell
    always_comb begin
      wr[g].load   = cmd_take && (op_t'(cmd.opcode) == OP_LOAD) &&
                     (cmd.source_index == SRC_W'(g));
      wr[g].remove = cmd_take && (op_t'(cmd.opcode) == OP_REMOVE) &&
                     (cmd.source_index == SRC_W'(g));
      wr[g].prio   = cmd.snapshot_priority;
      wr[g].stamp  = cmd.source_stamp;
      wr[g].recv   = cmd.received_time;
    end

    sfa_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .idx          (SRC_W'(g)),
      .wr           (wr[g]),
      .policy_prio  (src_prio[8*g +: 8]),
      .lease_ns     (lease_ns[g]),
      .tmo_ns       (tmo_ns),
      .now_ros      (now_ros),
      .eval_steady  (eval_steady),
      .active_index (act_i),
      .carry_in     (chain[g]),
      .valid_in     (chain_v[g]),
      .carry_out    (chain[g+1]),
      .valid_out    (chain_v[g+1])
    );
  end

  // Final decision from the verdict that left the last cell.
  scan_t            fin;
  logic             d_has;
  logic [SRC_W-1:0] d_src;
  logic [63:0]      d_stamp;
  ev_t              d_ev;
  err_t             d_err;
  logic             n_act_v, n_ch_v;
  logic [SRC_W-1:0] n_act_i, n_ch_i;
  logic [62:0]      n_since, elapsed;

  always_comb begin
    fin     = chain[NUM_SOURCES];
    d_has   = 1'b0;
    d_src   = '0;
    d_stamp = '0;
    d_ev    = EV_NONE;
    d_err   = ERR_NONE;
    n_act_v = act_v;
    n_act_i = act_i;
    n_ch_v  = ch_v;
    n_ch_i  = ch_i;
    n_since = (!ch_v || ch_i != fin.best_idx) ? eval_steady : since;
    elapsed = eval_steady - n_since;
    if (fin.err != ERR_NONE) begin
      // A bad slot leaves every piece of state as it was.
      d_err   = fin.err;
      n_since = since;
    end else if (!fin.any) begin
      d_ev    = act_v ? EV_LOST : EV_NONE;
      n_act_v = 1'b0;
      n_act_i = '0;
      n_ch_v  = 1'b0;
      n_since = since;
    end else if (!act_v || !fin.act_qual) begin
      // First pick, or the active source dropped out: take the best at once.
      d_has   = 1'b1;
      d_src   = fin.best_idx;
      d_stamp = fin.best_stamp;
      d_ev    = act_v ? EV_FALLBACK : EV_FIRST;
      n_act_v = 1'b1;
      n_act_i = fin.best_idx;
      n_ch_v  = 1'b0;
      n_since = since;
    end else if (fin.best_idx == act_i) begin
      d_has   = 1'b1;
      d_src   = fin.best_idx;
      d_stamp = fin.best_stamp;
      n_ch_v  = 1'b0;
      n_since = since;
    end else begin
      // A different source is best; it must hold that place for the switch hold.
      n_ch_v = 1'b1;
      n_ch_i = fin.best_idx;
      if (eval_steady < n_since) begin
        d_err = ERR_CHALLENGER;
      end else if (elapsed < {{(63-TMO_NS_W){1'b0}}, hold_ns}) begin
        d_has   = 1'b1;
        d_src   = act_i;
        d_stamp = fin.act_stamp;
      end else begin
        d_has   = 1'b1;
        d_src   = fin.best_idx;
        d_stamp = fin.best_stamp;
        d_ev    = EV_SWITCH;
        n_act_i = fin.best_idx;
        n_ch_v  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      now_ros     <= cmd.now_ros_time;
      eval_steady <= cmd.now_steady_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      start     <= 1'b0;
      res_valid <= 1'b0;
      act_v     <= 1'b0;
      act_i     <= '0;
      ch_v      <= 1'b0;
      ch_i      <= '0;
      since     <= '0;
      out_has   <= 1'b0;
      out_src   <= '0;
      out_stamp <= '0;
      out_ev    <= EV_NONE;
      out_err   <= ERR_NONE;
    end else begin
      start <= 1'b0;
      // A new result may replace one that the sink takes at this very edge.
      if (finish) begin
        res_valid <= 1'b1;
      end else if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_take && op_t'(cmd.opcode) == OP_EVAL) begin
            start <= 1'b1;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain_v[NUM_SOURCES]) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finish) begin
            out_has   <= d_has;
            out_src   <= d_src;
            out_stamp <= d_stamp;
            out_ev    <= d_ev;
            out_err   <= d_err;
            act_v     <= n_act_v;
            act_i     <= n_act_i;
            ch_v      <= n_ch_v;
            ch_i      <= n_ch_i;
            since     <= n_since;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/sfa_checker.sv @@
// Port-level checks on the result channel of the source failover arbiter.
// Depends on sfa_pkg; bound to source_failover_arbiter at the end of this file.
module sfa_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        has_selection,
  input logic [2:0]  selected_source,
  input logic [63:0] selected_stamp,
  input logic [2:0]  decision_event,
  input logic [1:0]  error_code
);
  import sfa_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(selected_stamp) &&
    $stable(decision_event) && $stable(error_code))
    else $error("result beat changed while stalled");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && error_code != ERR_NONE |-> !has_selection &&
    decision_event == EV_NONE)
    else $error("error beat carries a selection or event");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !has_selection |-> selected_source == 3'd0 &&
    selected_stamp == 64'd0)
    else $error("beat without selection has nonzero source or stamp");

  a_event_sel: assert property (@(posedge clk) disable iff (rst)
    res_valid && (decision_event == EV_FIRST || decision_event == EV_FALLBACK ||
    decision_event == EV_SWITCH) |-> has_selection)
    else $error("selection event without a selected source");

endmodule

bind source_failover_arbiter sfa_checker u_sfa_checker (
  .clk             (clk),
  .rst             (rst),
  .res_valid       (res.valid),
  .res_ready       (res.ready),
  .has_selection   (res.has_selection),
  .selected_source (res.selected_source),
  .selected_stamp  (res.selected_stamp),
  .decision_event  (res.decision_event),
  .error_code      (res.error_code)
);

@@ tb/sv/sfa_decision_monitor.sv @@
`timescale 1ns / 100ps
// Checker for the source failover arbiter: watches the config, command and result channels.
// Depends on sfa_pkg and the channel interfaces in sfa_if.sv.
module sfa_decision_monitor (
  input  logic clk,
  input  logic rst,
  sfa_cmd_if   cmd,
  sfa_res_if   res,
  sfa_cfg_if   cfg,
  output int   fail_count,
  output int   pending
);
  import sfa_pkg::*;

  typedef struct {
    logic        has;
    logic [2:0]  src;
    logic [63:0] stamp;
    ev_t         ev;
    err_t        err;
  } decision_t;

  decision_t decision_q[$];

  logic [31:0] tmo_ms, hold_ms;
  logic [63:0] policy, lease_lo, lease_hi;

  bit          present [NUM_SOURCES];
  logic [7:0]  sprio   [NUM_SOURCES];
  logic [63:0] sstamp  [NUM_SOURCES];
  logic [62:0] srecv   [NUM_SOURCES];
  bit          act_valid, ch_valid;
  int          act_idx, ch_idx;
  logic [62:0] ch_since;

  task automatic push_decision(logic has, int src, logic [63:0] stamp, ev_t ev, err_t err);
    decision_t d;
    d.has = has;
    d.src = src[2:0];
    d.stamp = stamp;
    d.ev = ev;
    d.err = err;
    decision_q.insert(decision_q.size(), d);
  endtask

  // Mirrors one evaluate tick: qualification scan, ranking, then the failover
  // and hold-off state machine.
  task automatic predict_decision(logic [63:0] ros_raw, logic [62:0] steady);
    bit          qual [NUM_SOURCES];
    bit          any, fresh;
    int          best;
    longint      nr, st;
    logic [63:0] lword, lim, tmo_lim;
    logic [15:0] l16;
    nr = $signed(ros_raw);
    any = 0;
    best = 0;
    tmo_lim = {32'd0, tmo_ms} * 64'd1000000;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      qual[i] = 0;
      if (present[i]) begin
        if (sprio[i] != policy[8*i +: 8]) begin
          push_decision(0, 0, 0, EV_NONE, ERR_PRIO);
          return;
        end
        if (steady < srecv[i]) begin
          push_decision(0, 0, 0, EV_NONE, ERR_STEADY);
          return;
        end
        st = $signed(sstamp[i]);
        fresh = !(nr < 0 || st < 0) && (st > nr || 64'(nr - st) <= tmo_lim);
        lword = (i < 4) ? lease_lo : lease_hi;
        l16 = lword[16*(i%4) +: 16];
        lim = 64'(l16) * 64'd1000000;
        qual[i] = fresh && ({1'b0, steady - srecv[i]} <= lim);
      end
    end
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (qual[i]) begin
        if (!any) begin
          any = 1;
          best = i;
        end else if (sprio[i] != sprio[best]) begin
          if (sprio[i] > sprio[best]) best = i;
        end else if ($signed(sstamp[i]) > $signed(sstamp[best])) begin
          best = i;
        end
      end
    end
    if (!any) begin
      push_decision(0, 0, 0, act_valid ? EV_LOST : EV_NONE, ERR_NONE);
      act_valid = 0;
      act_idx = 0;
      ch_valid = 0;
    end else if (!act_valid) begin
      act_valid = 1;
      act_idx = best;
      ch_valid = 0;
      push_decision(1, best, sstamp[best], EV_FIRST, ERR_NONE);
    end else if (!qual[act_idx]) begin
      act_idx = best;
      ch_valid = 0;
      push_decision(1, best, sstamp[best], EV_FALLBACK, ERR_NONE);
    end else if (best == act_idx) begin
      ch_valid = 0;
      push_decision(1, best, sstamp[best], EV_NONE, ERR_NONE);
    end else begin
      if (!ch_valid || ch_idx != best) begin
        ch_valid = 1;
        ch_idx = best;
        ch_since = steady;
      end
      if (steady < ch_since)
        push_decision(0, 0, 0, EV_NONE, ERR_CHALLENGER);
      else if ({1'b0, steady - ch_since} < {32'd0, hold_ms} * 64'd1000000)
        push_decision(1, act_idx, sstamp[act_idx], EV_NONE, ERR_NONE);
      else begin
        act_idx = best;
        ch_valid = 0;
        push_decision(1, best, sstamp[best], EV_SWITCH, ERR_NONE);
      end
    end
  endtask

  always @(posedge clk) begin
    decision_t d;
    if (rst) begin
      decision_q.delete();
      tmo_ms = 32'd100;
      hold_ms = 32'd200;
      policy = '0;
      lease_lo = '0;
      lease_hi = '0;
      foreach (present[i]) present[i] = 0;
      act_valid = 0;
      act_idx = 0;
      ch_valid = 0;
      ch_idx = 0;
      ch_since = '0;
    end else begin
      // Results are compared before this edge's command is predicted; a result
      // can never belong to the command accepted at the same edge.
      if (res.valid && res.ready) begin
        if (decision_q.size() == 0) begin
          $error("result beat with no decision expected");
          fail_count++;
        end else begin
          d = decision_q.pop_front();
          if (res.has_selection !== d.has) begin
            $error("has_selection: expected %0d, got %0d", d.has, res.has_selection);
            fail_count++;
          end
          if (res.selected_source !== d.src) begin
            $error("selected_source: expected %0d, got %0d", d.src, res.selected_source);
            fail_count++;
          end
          if (res.selected_stamp !== d.stamp) begin
            $error("selected_stamp: expected %h, got %h", d.stamp, res.selected_stamp);
            fail_count++;
          end
          if (res.decision_event !== d.ev) begin
            $error("decision_event: expected %0d, got %0d", d.ev, res.decision_event);
            fail_count++;
          end
          if (res.error_code !== d.err) begin
            $error("error_code: expected %0d, got %0d", d.err, res.error_code);
            fail_count++;
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_CMD_TIMEOUT: tmo_ms = cfg.data[31:0];
          CFG_SWITCH_HOLD: hold_ms = cfg.data[31:0];
          CFG_PRIORITIES:  policy = cfg.data;
          CFG_LEASE_LOW:   lease_lo = cfg.data;
          CFG_LEASE_HIGH:  lease_hi = cfg.data;
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        case (cmd.opcode)
          OP_LOAD: begin
            present[cmd.source_index] = 1;
            sprio[cmd.source_index] = cmd.snapshot_priority;
            sstamp[cmd.source_index] = cmd.source_stamp;
            srecv[cmd.source_index] = cmd.received_time;
          end
          OP_REMOVE: present[cmd.source_index] = 0;
          OP_EVAL:   predict_decision(cmd.now_ros_time, cmd.now_steady_time);
          default: ;
        endcase
      end
    end
    pending = decision_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

  final begin
    if (decision_q.size() != 0)
      $error("%0d decisions never arrived", decision_q.size());
  end

endmodule

@@ tb/sv/source_failover_arbiter_tb.sv @@
`timescale 1ns / 100ps
// Top of the source failover arbiter testbench: clock, reset, stimulus and verdict.
// Depends on sfa_pkg, sfa_if.sv, the block itself and sfa_decision_monitor.
module source_failover_arbiter_tb;
  import sfa_pkg::*;

  localparam longint MS = 64'd1000000;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst;
  int   fails, pending;

  sfa_cmd_if cmd();
  sfa_res_if res();
  sfa_cfg_if cfg();

  source_failover_arbiter dut (.clk(clk), .rst(rst), .cmd(cmd), .res(res), .cfg(cfg));

  sfa_decision_monitor mon (
    .clk(clk), .rst(rst), .cmd(cmd), .res(res), .cfg(cfg),
    .fail_count(fails), .pending(pending)
  );

  // The stimulus keeps its own view of the time bases and of the policy bytes,
  // so that most loaded snapshots claim the right priority and age sensibly.
  logic [62:0] steady_now;
  logic [63:0] ros_now;
  logic [63:0] ros_offset;
  logic [7:0]  policy_byte [NUM_SOURCES];
  bit          no_gaps;
  bit          sink_eager;
  bit          done;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Result sink: draws a stall before every beat, with eager stretches where
  // ready simply stays high.
  initial begin
    int stall;
    res.ready <= 0;
    sink_eager = 0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 40) == 0) sink_eager = !sink_eager;
      stall = sink_eager ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        res.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1;
      do @(posedge clk); while (!res.valid);
    end
  end

  // One command beat. The valid is dropped only when a gap follows, so it is
  // never lowered and raised within the same edge.
  task automatic send_beat(logic [1:0] op, logic [2:0] idx, logic [7:0] prio,
                           logic [63:0] stamp, logic [62:0] recv,
                           logic [63:0] ros, logic [62:0] steady);
    int gap;
    cmd.opcode <= op;
    cmd.source_index <= idx;
    cmd.snapshot_priority <= prio;
    cmd.source_stamp <= stamp;
    cmd.received_time <= recv;
    cmd.now_ros_time <= ros;
    cmd.now_steady_time <= steady;
    cmd.valid <= 1;
    do @(posedge clk); while (!cmd.ready);
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      cmd.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_slot(int idx, logic [7:0] prio, logic [63:0] stamp, logic [62:0] recv);
    send_beat(OP_LOAD, idx[2:0], prio, stamp, recv, {$urandom, $urandom},
              63'({$urandom, $urandom}));
  endtask

  task automatic remove_slot(int idx);
    send_beat(OP_REMOVE, idx[2:0], 8'($urandom), {$urandom, $urandom},
              63'({$urandom, $urandom}), {$urandom, $urandom}, 63'({$urandom, $urandom}));
  endtask

  task automatic evaluate_at(logic [63:0] ros, logic [62:0] steady);
    send_beat(OP_EVAL, 3'($urandom), 8'($urandom), {$urandom, $urandom},
              63'({$urandom, $urandom}), ros, steady);
  endtask

  // Advances both clocks by a random step; now and then the steady clock
  // steps back, which is what provokes the challenger-start error.
  task automatic advance_clocks(int max_ms);
    if ($urandom_range(0, 19) == 0)
      steady_now = 63'(steady_now - $urandom_range(1, 50) * MS);
    else
      steady_now = 63'(steady_now + $urandom_range(0, max_ms) * MS +
                       $urandom_range(0, 999999));
    ros_now = {1'b0, steady_now} + ros_offset;
  endtask

  // Registers are written only while the block is idle: wait out every
  // expected decision, then a full evaluate latency on top of that.
  task automatic write_config(logic [31:0] tmo, logic [31:0] hold, logic [63:0] prios,
                              logic [63:0] lease_lo, logic [63:0] lease_hi);
    logic [63:0] values [5];
    logic [2:0]  regs   [5];
    cmd.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (NUM_SOURCES + 4) @(posedge clk);
    values = '{{32'd0, tmo}, {32'd0, hold}, prios, lease_lo, lease_hi};
    regs = '{CFG_CMD_TIMEOUT, CFG_SWITCH_HOLD, CFG_PRIORITIES, CFG_LEASE_LOW, CFG_LEASE_HIGH};
    for (int k = 0; k < 5; k++) begin
      cfg.index <= regs[k];
      cfg.data <= values[k];
      cfg.valid <= 1;
      do @(posedge clk); while (!cfg.ready);
    end
    cfg.valid <= 0;
    for (int i = 0; i < NUM_SOURCES; i++) policy_byte[i] = prios[8*i +: 8];
  endtask

  // Random traffic: mostly well-formed snapshots with the right priority and
  // plausible ages, mixed with mismatches, future receive times, raw bit
  // patterns and unused opcodes.
  task automatic random_phase(int items);
    int          kind, idx;
    logic [7:0]  prio;
    logic [63:0] stamp;
    logic [62:0] recv;
    logic [63:0] ros;
    for (int n = 0; n < items; n++) begin
      kind = $urandom_range(0, 99);
      idx = $urandom_range(0, NUM_SOURCES - 1);
      if (kind < 45) begin
        advance_clocks(150);
        ros = ($urandom_range(0, 29) == 0) ? {$urandom, $urandom} : ros_now;
        evaluate_at(ros, steady_now);
      end else if (kind < 80) begin
        prio = ($urandom_range(0, 9) == 0) ? 8'($urandom) : policy_byte[idx];
        case ($urandom_range(0, 19))
          0, 1:    stamp = ros_now + $urandom_range(1, 100) * MS;
          2, 3:    stamp = {$urandom, $urandom};
          default: stamp = ros_now - $urandom_range(0, 250) * MS - $urandom_range(0, 999);
        endcase
        case ($urandom_range(0, 24))
          0, 1:    recv = 63'(steady_now + $urandom_range(1, 30) * MS);
          2:       recv = 63'({$urandom, $urandom});
          default: recv = 63'(steady_now - $urandom_range(0, 200) * MS -
                              $urandom_range(0, 999));
        endcase
        load_slot(idx, prio, stamp, recv);
      end else if (kind < 96) begin
        remove_slot(idx);
      end else begin
        send_beat(2'd3, 3'($urandom), 8'($urandom), {$urandom, $urandom},
                  63'({$urandom, $urandom}), {$urandom, $urandom},
                  63'({$urandom, $urandom}));
      end
    end
  endtask

  function automatic logic [63:0] small_policy();
    logic [63:0] p;
    for (int i = 0; i < NUM_SOURCES; i++) p[8*i +: 8] = 8'($urandom_range(0, 3));
    return p;
  endfunction

  function automatic logic [63:0] lease_word(int lo_ms, int hi_ms);
    logic [63:0] w;
    for (int i = 0; i < 4; i++) w[16*i +: 16] = 16'($urandom_range(lo_ms, hi_ms));
    return w;
  endfunction

  initial begin
    logic [62:0] t0;
    cmd.valid <= 0;
    cmd.opcode <= OP_EVAL;
    cmd.source_index <= '0;
    cmd.snapshot_priority <= '0;
    cmd.source_stamp <= '0;
    cmd.received_time <= '0;
    cmd.now_ros_time <= '0;
    cmd.now_steady_time <= '0;
    cfg.valid <= 0;
    cfg.index <= CFG_CMD_TIMEOUT;
    cfg.data <= '0;
    no_gaps = 0;
    done = 0;
    steady_now = 63'd1_000_000_000_000;
    ros_offset = 64'd500_000_000_000;
    ros_now = {1'b0, steady_now} + ros_offset;
    rst <= 1;
    repeat (10) @(posedge clk);
    rst <= 0;

    // Directed part. Sources 0..3 rank 1, 2, 5, 5; source 7 has a zero lease.
    write_config(32'd100, 32'd50, 64'h09_00_00_00_05_05_02_01,
                 64'h03E8_03E8_03E8_03E8, 64'h0000_03E8_03E8_03E8);
    t0 = steady_now;
    evaluate_at(ros_now, t0);                                    // empty table
    load_slot(0, 8'd1, ros_now - 10 * MS, t0);
    evaluate_at(ros_now, t0);                                    // first selection
    load_slot(2, 8'd5, ros_now - 20 * MS, t0);
    evaluate_at(ros_now, 63'(t0 + 1 * MS));                      // challenger appears
    evaluate_at(ros_now, 63'(t0 + 1 * MS - 1));                  // steady went backwards
    evaluate_at(ros_now + 40 * MS, 63'(t0 + 60 * MS));           // hold met: switch
    load_slot(3, 8'd5, ros_now - 5 * MS, t0);                    // same rank, younger
    evaluate_at(ros_now + 40 * MS, 63'(t0 + 60 * MS));
    remove_slot(2);
    remove_slot(3);
    evaluate_at(ros_now + 40 * MS, 63'(t0 + 61 * MS));           // fallback to source 0
    load_slot(1, 8'd7, ros_now, t0);                             // claims the wrong rank
    evaluate_at(ros_now, 63'(t0 + 62 * MS));
    load_slot(1, 8'd2, ros_now, 63'h7FFF_FFFF_FFFF_FFFF);        // received in the future
    evaluate_at(ros_now, 63'(t0 + 62 * MS));
    remove_slot(1);
    load_slot(7, 8'd9, 64'h7FFF_FFFF_FFFF_FFFF, 63'd0);          // stamp far ahead, lease 0
    load_slot(4, 8'd0, 64'h8000_0000_0000_0000, t0);             // negative stamp
    evaluate_at(64'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
    evaluate_at(64'h8000_0000_0000_0000, 63'(t0 + 63 * MS));     // negative now: no selection
    send_beat(2'd3, 3'd7, 8'hFF, '1, '1, '1, '1);                // unused opcode
    for (int i = 0; i < NUM_SOURCES; i++) remove_slot(i);
    steady_now = 63'(t0 + 100 * MS);
    ros_now = {1'b0, steady_now} + ros_offset;

    // Random phases, each under a different register setting, extremes included.
    write_config($urandom_range(50, 200), $urandom_range(0, 300), small_policy(),
                 lease_word(100, 400), lease_word(100, 400));
    random_phase(90);
    no_gaps = 1;
    write_config(32'd0, 32'd0, small_policy(), '1, '1);
    random_phase(90);
    no_gaps = 0;
    write_config('1, '1, small_policy(), '0, lease_word(150, 300));
    random_phase(80);
    write_config($urandom_range(20, 300), $urandom_range(0, 300), '1,
                 lease_word(50, 300), lease_word(50, 300));
    random_phase(90);
    no_gaps = $urandom_range(0, 1);
    write_config($urandom_range(100, 300), $urandom_range(0, 400), '0,
                 {$urandom, $urandom}, {$urandom, $urandom});
    random_phase(90);
    no_gaps = 0;
    write_config($urandom, $urandom_range(0, 200), small_policy(),
                 lease_word(0, 65535), lease_word(100, 300));
    random_phase(90);

    cmd.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (NUM_SOURCES + 10) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
